// File: src/tok_scan_pkg.sv
// shared types, character codes and helpers for the token scanner
`default_nettype none
package tok_scan_pkg;

	localparam int MAX_LEXEME = 31;
	localparam int LEN_CAP    = (MAX_LEXEME < 31) ? MAX_LEXEME : 31;
	localparam int TOKQ_DEPTH = 4;
	localparam int TOKQ_AW    = $clog2(TOKQ_DEPTH);
	localparam int TOKQ_CW    = $clog2(TOKQ_DEPTH + 1);

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0A;

	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_EOT  = 1'b1;

	typedef enum logic [2:0] {
		ST_START  = 3'd0,
		ST_IDENT  = 3'd1,
		ST_INT    = 3'd2,
		ST_ASSIGN = 3'd3,
		ST_ARITH  = 3'd4,
		ST_REL    = 3'd5
	} scan_state_t;

	typedef enum logic [2:0] {
		K_REL    = 3'd0,
		K_ASSIGN = 3'd1,
		K_SEMI   = 3'd2,
		K_ARITH  = 3'd3,
		K_IDENT  = 3'd4,
		K_INT    = 3'd5,
		K_ERR    = 3'd6
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] line;
		logic [23:0] start;
		logic [4:0]  length;
		logic        too_long;
	} token_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_arith(input logic [7:0] c);
		return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH
			|| c == CH_PCT;
	endfunction

endpackage
`default_nettype wire

// File: src/token_scanner_unit.sv
// Byte-serial lexical scanner: takes one character or end-of-text beat per cycle
// and delivers identifier, integer, operator, semicolon and error tokens with
// line, start offset and length. A character beat is taken every cycle while
// the four-entry token queue has room for two more tokens; one beat can yield
// up to two tokens (a pending lexeme closed by the character, then the
// character itself), so the sustained rate is one character per cycle as long
// as the token side keeps up with the tokens produced. A token is queued in the
// cycle after the beat that completes it and reaches the output behind any older tokens.
`default_nettype none
module token_scanner_unit (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        char_valid,
	output logic              char_stall,
	input  wire  logic        op,
	input  wire  logic [7:0]  ch,
	output logic              tok_valid,
	input  wire  logic        tok_stall,
	output logic [2:0]        kind,
	output logic [15:0]       line,
	output logic [23:0]       start_res,
	output logic [4:0]        length,
	output logic              too_long
);

	localparam int AW = tok_scan_pkg::TOKQ_AW;
	localparam int CW = tok_scan_pkg::TOKQ_CW;

	tok_scan_pkg::scan_state_t st_q, st_d;
	logic [23:0] tok_start_q, tok_start_d;
	logic [4:0]  tok_len_q, tok_len_d;
	logic        ovf_q, ovf_d;
	logic [7:0]  first_op_q, first_op_d;
	logic [23:0] pos_q, pos_d;
	logic [15:0] line_q, line_d;

	logic                push;
	logic                pop;
	logic                pend_emit;
	tok_scan_pkg::kind_t pend_kind;
	logic [4:0]          pend_len;
	logic                rescan;
	logic                rs_emit;
	tok_scan_pkg::kind_t rs_kind;
	logic                grow;
	tok_scan_pkg::token_t tok0, tok1;
	logic [1:0]          n_push;

	tok_scan_pkg::token_t tokq [tok_scan_pkg::TOKQ_DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign char_stall = cnt_q > CW'(tok_scan_pkg::TOKQ_DEPTH - 2);
	assign push       = char_valid && !char_stall;
	assign tok_valid  = cnt_q != '0;
	assign pop        = tok_valid && !tok_stall;

	// decode of the current beat against the scan state
	always_comb begin
		pend_emit = 1'b0;
		pend_kind = tok_scan_pkg::K_REL;
		pend_len  = tok_len_q;
		rescan    = 1'b0;
		grow      = 1'b0;
		if (op == tok_scan_pkg::OP_EOT) begin
			pend_emit = st_q != tok_scan_pkg::ST_START;
			unique case (st_q)
				tok_scan_pkg::ST_IDENT:  pend_kind = tok_scan_pkg::K_IDENT;
				tok_scan_pkg::ST_INT:    pend_kind = tok_scan_pkg::K_INT;
				tok_scan_pkg::ST_ASSIGN: pend_kind = tok_scan_pkg::K_ASSIGN;
				tok_scan_pkg::ST_ARITH:  pend_kind = tok_scan_pkg::K_ARITH;
				default:                 pend_kind = tok_scan_pkg::K_REL;
			endcase
		end else begin
			unique case (st_q)
				tok_scan_pkg::ST_IDENT: begin
					if (tok_scan_pkg::is_letter(ch) || tok_scan_pkg::is_digit(ch)) begin
						grow = 1'b1;
					end else begin
						pend_emit = 1'b1;
						pend_kind = tok_scan_pkg::K_IDENT;
						rescan    = 1'b1;
					end
				end
				tok_scan_pkg::ST_INT: begin
					if (tok_scan_pkg::is_digit(ch)) begin
						grow = 1'b1;
					end else begin
						pend_emit = 1'b1;
						pend_kind = tok_scan_pkg::K_INT;
						rescan    = 1'b1;
					end
				end
				tok_scan_pkg::ST_ASSIGN: begin
					pend_emit = 1'b1;
					if (ch == tok_scan_pkg::CH_EQ) begin
						pend_kind = tok_scan_pkg::K_REL;
						pend_len  = 5'd2;
					end else begin
						pend_kind = tok_scan_pkg::K_ASSIGN;
						rescan    = 1'b1;
					end
				end
				tok_scan_pkg::ST_ARITH: begin
					pend_emit = 1'b1;
					pend_kind = tok_scan_pkg::K_ARITH;
					if (ch == first_op_q && (ch == tok_scan_pkg::CH_PLUS
						|| ch == tok_scan_pkg::CH_MINUS || ch == tok_scan_pkg::CH_STAR)) begin
						pend_len = 5'd2;
					end else begin
						rescan = 1'b1;
					end
				end
				tok_scan_pkg::ST_REL: begin
					pend_emit = 1'b1;
					pend_kind = tok_scan_pkg::K_REL;
					if (ch == tok_scan_pkg::CH_EQ) begin
						pend_len = 5'd2;
					end else begin
						rescan = 1'b1;
					end
				end
				default: rescan = 1'b1;
			endcase
		end
	end

	// character scanned from the start state
	always_comb begin
		rs_emit = 1'b0;
		rs_kind = tok_scan_pkg::K_ERR;
		if (rescan) begin
			if (ch == tok_scan_pkg::CH_SEMI) begin
				rs_emit = 1'b1;
				rs_kind = tok_scan_pkg::K_SEMI;
			end else if (!(ch == tok_scan_pkg::CH_SPACE || ch == tok_scan_pkg::CH_NL
				|| tok_scan_pkg::is_letter(ch) || tok_scan_pkg::is_digit(ch)
				|| ch == tok_scan_pkg::CH_EQ || tok_scan_pkg::is_arith(ch)
				|| ch == tok_scan_pkg::CH_LT || ch == tok_scan_pkg::CH_GT)) begin
				rs_emit = 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		st_d        = st_q;
		tok_start_d = tok_start_q;
		tok_len_d   = tok_len_q;
		ovf_d       = ovf_q;
		first_op_d  = first_op_q;
		pos_d       = pos_q;
		line_d      = line_q;
		if (pend_emit) begin
			st_d      = tok_scan_pkg::ST_START;
			tok_len_d = '0;
			ovf_d     = 1'b0;
		end
		if (op == tok_scan_pkg::OP_EOT) begin
			st_d = tok_scan_pkg::ST_START;
		end else begin
			pos_d = pos_q + 24'd1;
			if (grow) begin
				if (tok_len_q >= 5'(tok_scan_pkg::LEN_CAP)) begin
					ovf_d = 1'b1;
				end else begin
					tok_len_d = tok_len_q + 5'd1;
				end
			end
			if (rescan) begin
				st_d = tok_scan_pkg::ST_START;
				if (ch == tok_scan_pkg::CH_NL) begin
					line_d = line_q + 16'd1;
				end else if (ch != tok_scan_pkg::CH_SPACE && !rs_emit) begin
					tok_start_d = pos_q;
					tok_len_d   = 5'd1;
					ovf_d       = 1'b0;
					if (tok_scan_pkg::is_letter(ch)) begin
						st_d = tok_scan_pkg::ST_IDENT;
					end else if (tok_scan_pkg::is_digit(ch)) begin
						st_d = tok_scan_pkg::ST_INT;
					end else if (ch == tok_scan_pkg::CH_EQ) begin
						st_d = tok_scan_pkg::ST_ASSIGN;
					end else if (tok_scan_pkg::is_arith(ch)) begin
						st_d       = tok_scan_pkg::ST_ARITH;
						first_op_d = ch;
					end else begin
						st_d = tok_scan_pkg::ST_REL;
					end
				end
			end
		end
	end

	// tokens produced by this beat, in order
	always_comb begin
		tok1.kind     = rs_kind;
		tok1.line     = line_q;
		tok1.start    = pos_q;
		tok1.length   = 5'd1;
		tok1.too_long = 1'b0;
		if (pend_emit) begin
			tok0.kind     = pend_kind;
			tok0.line     = line_q;
			tok0.start    = tok_start_q;
			tok0.length   = pend_len;
			tok0.too_long = ovf_q;
		end else begin
			tok0 = tok1;
		end
		n_push = {1'b0, pend_emit} + {1'b0, rs_emit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= tok_scan_pkg::ST_START;
			tok_start_q <= '0;
			tok_len_q   <= '0;
			ovf_q       <= 1'b0;
			first_op_q  <= '0;
			pos_q       <= '0;
			line_q      <= '0;
		end else if (push) begin
			st_q        <= st_d;
			tok_start_q <= tok_start_d;
			tok_len_q   <= tok_len_d;
			ovf_q       <= ovf_d;
			first_op_q  <= first_op_d;
			pos_q       <= pos_d;
			line_q      <= line_d;
		end
	end

	// token queue
	always_ff @(posedge clk) begin
		if (push && n_push != 2'd0) begin
			tokq[wr_ptr_q] <= tok0;
		end
		if (push && n_push == 2'd2) begin
			tokq[wr_ptr_q + AW'(1)] <= tok1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(n_push);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			cnt_q <= cnt_q + (push ? CW'(n_push) : CW'(0)) - (pop ? CW'(1) : CW'(0));
		end
	end

	assign kind      = tokq[rd_ptr_q].kind;
	assign line      = tokq[rd_ptr_q].line;
	assign start_res = tokq[rd_ptr_q].start;
	assign length    = tokq[rd_ptr_q].length;
	assign too_long  = tokq[rd_ptr_q].too_long;

endmodule
`default_nettype wire

// File: tb/sv/token_scanner_unit_tb.sv
// self-checking testbench for the token scanner: directed script, then random text under flow control
`timescale 1ns / 1ps
module token_scanner_unit_tb;
	import tok_scan_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 8;

	typedef struct packed {
		logic       op;
		logic [7:0] ch;
		logic       fixed;
		token_t     tok;
	} script_row_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        char_valid = 1'b0;
	logic        op         = OP_CHAR;
	logic [7:0]  ch         = 8'h00;
	logic        tok_stall  = 1'b0;
	logic        char_stall;
	logic        tok_valid;
	logic [2:0]  kind;
	logic [15:0] line;
	logic [23:0] start_res;
	logic [4:0]  length;
	logic        too_long;

	// scanner shadow state
	scan_state_t lex_state    = ST_START;
	logic [23:0] lex_start    = '0;
	logic [4:0]  lex_len      = '0;
	logic        lex_over     = 1'b0;
	logic [7:0]  lex_first_op = '0;
	logic [23:0] char_pos     = '0;
	logic [15:0] line_no      = '0;

	token_t      beat_tokens[$];
	token_t      tokens_due[$];
	script_row_t script[$];

	logic        fixed_on  = 1'b0;
	token_t      fixed_tok = '0;
	int          idle_pct  = 0;
	int          stall_pct = 0;
	int          beats_taken    = 0;
	int          eot_beats      = 0;
	int          tokens_checked = 0;
	int          saturated      = 0;
	int          failures       = 0;
	int          idle_cycles    = 0;

	logic [7:0] op_chars[9] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_SEMI, CH_EQ,
		CH_LT, CH_GT};

	token_scanner_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.op         (op),
		.ch         (ch),
		.tok_valid  (tok_valid),
		.tok_stall  (tok_stall),
		.kind       (kind),
		.line       (line),
		.start_res  (start_res),
		.length     (length),
		.too_long   (too_long)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) tok_stall <= ($urandom_range(0, 99) < stall_pct);

	function automatic logic char_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic char_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic char_arith(logic [7:0] c);
		return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH || c == CH_PCT;
	endfunction

	function automatic void emit_token(kind_t k, logic [23:0] s, logic [4:0] n, logic f);
		token_t t;
		t.kind     = k;
		t.line     = line_no;
		t.start    = s;
		t.length   = n;
		t.too_long = f;
		beat_tokens.push_back(t);
	endfunction

	function automatic void close_lexeme(kind_t k);
		emit_token(k, lex_start, lex_len, lex_over);
		lex_state = ST_START;
		lex_len   = '0;
		lex_over  = 1'b0;
	endfunction

	function automatic void open_lexeme(scan_state_t s);
		lex_state = s;
		lex_start = char_pos;
		lex_len   = 5'd1;
		lex_over  = 1'b0;
	endfunction

	function automatic void extend_lexeme();
		if (lex_len >= LEN_CAP)
			lex_over = 1'b1;
		else
			lex_len = lex_len + 5'd1;
	endfunction

	function automatic void scan_fresh(logic [7:0] c);
		if (c == CH_SPACE)
			return;
		if (c == CH_NL) begin
			line_no = line_no + 16'd1;
			return;
		end
		if (char_alpha(c))
			open_lexeme(ST_IDENT);
		else if (char_digit(c))
			open_lexeme(ST_INT);
		else if (c == CH_SEMI)
			emit_token(K_SEMI, char_pos, 5'd1, 1'b0);
		else if (c == CH_EQ)
			open_lexeme(ST_ASSIGN);
		else if (char_arith(c)) begin
			open_lexeme(ST_ARITH);
			lex_first_op = c;
		end else if (c == CH_LT || c == CH_GT)
			open_lexeme(ST_REL);
		else
			emit_token(K_ERR, char_pos, 5'd1, 1'b0);
	endfunction

	// tokens caused by one accepted beat land in beat_tokens
	function automatic void predict_beat(logic o, logic [7:0] c);
		logic again;
		again = 1'b0;
		beat_tokens.delete();
		if (o == OP_EOT) begin
			case (lex_state)
				ST_IDENT:  close_lexeme(K_IDENT);
				ST_INT:    close_lexeme(K_INT);
				ST_ASSIGN: close_lexeme(K_ASSIGN);
				ST_ARITH:  close_lexeme(K_ARITH);
				ST_REL:    close_lexeme(K_REL);
				default:   lex_state = ST_START;
			endcase
			return;
		end
		case (lex_state)
			ST_IDENT: begin
				if (char_alpha(c) || char_digit(c))
					extend_lexeme();
				else begin
					close_lexeme(K_IDENT);
					again = 1'b1;
				end
			end
			ST_INT: begin
				if (char_digit(c))
					extend_lexeme();
				else begin
					close_lexeme(K_INT);
					again = 1'b1;
				end
			end
			ST_ASSIGN: begin
				if (c == CH_EQ) begin
					lex_len = 5'd2;
					close_lexeme(K_REL);
				end else begin
					close_lexeme(K_ASSIGN);
					again = 1'b1;
				end
			end
			ST_ARITH: begin
				if (c == lex_first_op && (c == CH_PLUS || c == CH_MINUS || c == CH_STAR)) begin
					lex_len = 5'd2;
					close_lexeme(K_ARITH);
				end else begin
					close_lexeme(K_ARITH);
					again = 1'b1;
				end
			end
			ST_REL: begin
				if (c == CH_EQ) begin
					lex_len = 5'd2;
					close_lexeme(K_REL);
				end else begin
					close_lexeme(K_REL);
					again = 1'b1;
				end
			end
			default: begin
				lex_state = ST_START;
				again = 1'b1;
			end
		endcase
		if (again)
			scan_fresh(c);
		char_pos = char_pos + 24'd1;
	endfunction

	function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk) begin
		token_t want;
		logic moved;
		moved = 1'b0;
		if (arst_n && tok_valid && !tok_stall) begin
			moved = 1'b1;
			if (tokens_due.size() == 0) begin
				$display("%0t: unexpected token kind %0d line %0d start %0d length %0d too_long %0b",
					$time, kind, line, start_res, length, too_long);
				failures++;
			end else begin
				want = tokens_due.pop_front();
				check_field("kind", want.kind, kind);
				check_field("line", want.line, line);
				check_field("start", want.start, start_res);
				check_field("length", want.length, length);
				check_field("too_long", want.too_long, too_long);
				tokens_checked++;
				if (too_long)
					saturated++;
			end
		end
		if (arst_n && char_valid && !char_stall) begin
			moved = 1'b1;
			predict_beat(op, ch);
			if (fixed_on)
				tokens_due.push_back(fixed_tok);
			else
				foreach (beat_tokens[i]) tokens_due.push_back(beat_tokens[i]);
			beats_taken++;
			if (op == OP_EOT)
				eot_beats++;
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, nothing moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_beat(logic o, logic [7:0] c, logic f = 1'b0, token_t t = '0);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			char_valid <= 1'b0;
			op <= 1'($urandom_range(0, 1));
			ch <= 8'($urandom);
			@(negedge clk);
		end
		fixed_on = f;
		fixed_tok = t;
		char_valid <= 1'b1;
		op <= o;
		ch <= c;
		do @(posedge clk); while (char_stall);
	endtask

	task automatic drain();
		@(negedge clk);
		char_valid <= 1'b0;
		while (tokens_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_letter();
		logic [7:0] r;
		r = 8'($urandom_range(0, 25));
		return $urandom_range(0, 1) ? "a" + r : "A" + r;
	endfunction

	function automatic logic [7:0] rand_digit();
		return "0" + 8'($urandom_range(0, 9));
	endfunction

	task automatic send_ident(int n);
		send_beat(OP_CHAR, rand_letter());
		for (int i = 1; i < n; i++)
			send_beat(OP_CHAR, ($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter());
	endtask

	task automatic send_number(int n);
		for (int i = 0; i < n; i++)
			send_beat(OP_CHAR, rand_digit());
	endtask

	task automatic send_piece();
		int pick;
		logic [7:0] c;
		pick = $urandom_range(0, 99);
		if (pick < 28)
			send_ident(($urandom_range(0, 19) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 6));
		else if (pick < 42)
			send_number(($urandom_range(0, 19) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 6));
		else if (pick < 62) begin
			c = op_chars[$urandom_range(0, 8)];
			send_beat(OP_CHAR, c);
			case ($urandom_range(0, 2))
				0: send_beat(OP_CHAR, c);
				1: send_beat(OP_CHAR, CH_EQ);
				default: ;
			endcase
		end else if (pick < 78)
			send_beat(OP_CHAR, ($urandom_range(0, 2) == 0) ? CH_NL : CH_SPACE);
		else if (pick < 90)
			send_beat(OP_CHAR, 8'($urandom));
		else if (pick < 95)
			send_beat(OP_EOT, 8'($urandom));
		else
			send_beat(OP_CHAR, 8'($urandom_range(33, 126)));
	endtask

	function automatic void add_row(logic o, logic [7:0] c, logic f = 1'b0, kind_t k = K_ERR,
			logic [23:0] s = '0);
		script_row_t r;
		r.op           = o;
		r.ch           = c;
		r.fixed        = f;
		r.tok.kind     = k;
		r.tok.line     = '0;
		r.tok.start    = s;
		r.tok.length   = 5'd1;
		r.tok.too_long = 1'b0;
		script.push_back(r);
	endfunction

	initial begin
		int goal;
		add_row(OP_CHAR, CH_SEMI, 1'b1, K_SEMI, 24'd0);
		add_row(OP_CHAR, 8'h00, 1'b1, K_ERR, 24'd1);
		add_row(OP_CHAR, 8'hFF, 1'b1, K_ERR, 24'd2);
		add_row(OP_CHAR, "a");
		add_row(OP_CHAR, "Z");
		add_row(OP_CHAR, "9");
		add_row(OP_CHAR, CH_SPACE);
		add_row(OP_CHAR, CH_NL);
		add_row(OP_CHAR, "0");
		add_row(OP_CHAR, CH_EQ);
		add_row(OP_CHAR, CH_EQ);
		add_row(OP_CHAR, CH_EQ);
		add_row(OP_CHAR, "x");
		add_row(OP_CHAR, CH_PLUS);
		add_row(OP_CHAR, CH_PLUS);
		add_row(OP_CHAR, CH_MINUS);
		add_row(OP_CHAR, CH_MINUS);
		add_row(OP_CHAR, CH_STAR);
		add_row(OP_CHAR, CH_STAR);
		add_row(OP_CHAR, CH_SLASH);
		add_row(OP_CHAR, CH_PCT);
		add_row(OP_CHAR, CH_LT);
		add_row(OP_CHAR, CH_EQ);
		add_row(OP_CHAR, CH_GT);
		add_row(OP_CHAR, "q");
		add_row(OP_EOT, 8'hFF);
		add_row(OP_EOT, 8'h00);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			send_beat(script[i].op, script[i].ch, script[i].fixed, script[i].tok);
		// saturating lexemes
		send_ident(35);
		send_beat(OP_CHAR, CH_SPACE);
		send_number(33);
		send_beat(OP_EOT, 8'h00);

		goal = 170;
		while (beats_taken < goal) send_piece();
		drain();

		idle_pct = 88;
		goal += 140;
		while (beats_taken < goal) send_piece();
		drain();

		idle_pct = 0;
		stall_pct = 88;
		goal += 140;
		while (beats_taken < goal) send_piece();
		drain();

		idle_pct = 30;
		stall_pct = 30;
		goal += 150;
		while (beats_taken < goal) send_piece();
		send_beat(OP_EOT, 8'h00);
		drain();

		$display("scanned %0d beats (%0d end of text) over four flow-control phases",
			beats_taken, eot_beats);
		$display("checked %0d tokens, %0d of them saturated", tokens_checked, saturated);
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
